/* rtl/drsp_pkg.sv */
// Shared types and codes for the deferred-reclaim slot pool.
`default_nettype none
package drsp_pkg;

  localparam int DRSP_SLOTS = 64;

  localparam int DRSP_CMD_W    = 3;
  localparam int DRSP_SLOT_W   = 6;
  localparam int DRSP_SERIAL_W = 64;
  localparam int DRSP_STATUS_W = 2;
  localparam int DRSP_PHASE_W  = 3;

  localparam logic [DRSP_CMD_W-1:0] CMD_RESERVE   = 3'd0;
  localparam logic [DRSP_CMD_W-1:0] CMD_MARK      = 3'd1;
  localparam logic [DRSP_CMD_W-1:0] CMD_ABANDON   = 3'd2;
  localparam logic [DRSP_CMD_W-1:0] CMD_PUBLISH   = 3'd3;
  localparam logic [DRSP_CMD_W-1:0] CMD_REFERENCE = 3'd4;
  localparam logic [DRSP_CMD_W-1:0] CMD_RETIRE    = 3'd5;
  localparam logic [DRSP_CMD_W-1:0] CMD_COLLECT   = 3'd6;
  localparam logic [DRSP_CMD_W-1:0] CMD_UNUSED    = 3'd7;

  localparam logic [DRSP_STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [DRSP_STATUS_W-1:0] ST_BADARG    = 2'd1;
  localparam logic [DRSP_STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [DRSP_STATUS_W-1:0] ST_BADSTATE  = 2'd3;

  localparam logic [DRSP_PHASE_W-1:0] PH_FREE      = 3'd0;
  localparam logic [DRSP_PHASE_W-1:0] PH_RESERVED  = 3'd1;
  localparam logic [DRSP_PHASE_W-1:0] PH_RECORDED  = 3'd2;
  localparam logic [DRSP_PHASE_W-1:0] PH_PUBLISHED = 3'd3;
  localparam logic [DRSP_PHASE_W-1:0] PH_RETIRED   = 3'd4;

  typedef struct packed {
    logic [DRSP_CMD_W-1:0]    command;
    logic [DRSP_SLOT_W-1:0]   slot;
    logic [DRSP_SERIAL_W-1:0] serial;
  } in_item_t;

  typedef struct packed {
    logic [DRSP_STATUS_W-1:0] status;
    logic [DRSP_SLOT_W-1:0]   granted_slot;
    logic [DRSP_SLOT_W-1:0]   collected_count;
  } out_item_t;

  // Classified command as it leaves the front end
  typedef struct packed {
    in_item_t item;
    logic     badarg;
  } work_t;

endpackage
`default_nettype wire

/* rtl/drsp_front.sv */
// Front end: classify incoming commands and buffer them in a two-entry queue.
`default_nettype none
module drsp_front import drsp_pkg::*; #(
  parameter int SLOTS = DRSP_SLOTS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  input  wire logic     hold_i,
  output logic          valid_o,
  output work_t         work_o,
  input  wire logic     pop_i
);

  work_t       ent_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        slot_ok, per_slot, do_push, do_pop;
  work_t       cls;

  // Slot 0 is the sentinel; anything at or above the pool size is out of range
  assign slot_ok  = (item_i.slot != '0) && (32'(item_i.slot) < 32'(SLOTS));
  assign per_slot = (item_i.command == CMD_MARK) || (item_i.command == CMD_ABANDON) ||
                    (item_i.command == CMD_PUBLISH) || (item_i.command == CMD_REFERENCE) ||
                    (item_i.command == CMD_RETIRE);

  always_comb begin
    cls.item   = item_i;
    cls.badarg = (item_i.command == CMD_UNUSED) || (per_slot && !slot_ok);
  end

  assign full_o  = (cnt_q == 2'd2) || hold_i;
  assign valid_o = (cnt_q != 2'd0);
  assign work_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/drsp_back.sv */
// Back end: slot phase, serial and free-stack memories and the command sequencer.
`default_nettype none
module drsp_back import drsp_pkg::*; #(
  parameter int SLOTS = DRSP_SLOTS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire work_t work_i,
  output logic       pop_o,
  output logic       res_valid_o,
  output out_item_t  res_o,
  input  wire logic  res_ready_i,
  output logic       clearing_o
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW    = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] SLOTS_M1 = SW'(SLOTS - 1);
  localparam logic [SW:0]   SLOTS_WK = (SW + 1)'(SLOTS);
  localparam logic [DW-1:0] SLOTS_D  = DW'(SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [DRSP_PHASE_W-1:0]  phase_mem [SLOTS];
  logic [DRSP_SERIAL_W-1:0] lr_mem    [SLOTS];
  logic [DRSP_SERIAL_W-1:0] rm_mem    [SLOTS];
  logic [SW-1:0]            stk_mem   [SLOTS];

  logic [2:0]               state_q, state_d;
  logic [SW-1:0]            clr_q, clr_d;
  work_t                    cmd_q;
  logic [DW-1:0]            depth_q, depth_d;
  logic [DRSP_PHASE_W-1:0]  ph_rd_q;
  logic [DRSP_SERIAL_W-1:0] lr_rd_q, rm_rd_q;
  logic [SW-1:0]            stk_rd_q;
  logic [SW:0]              wk_q, wk_d;
  logic                     ev_vld_q, ev_vld_d;
  logic [SW-1:0]            ev_idx_q, ev_idx_d;
  logic [DRSP_SLOT_W-1:0]   cnt_q, cnt_d;

  logic [SW-1:0]            idx, rd_addr, stk_ra;
  logic                     ph_we, lr_we, rm_we, stk_we;
  logic [SW-1:0]            ph_wa, lr_wa, stk_wa;
  logic [DRSP_PHASE_W-1:0]  ph_wd;
  logic [DRSP_SERIAL_W-1:0] lr_wd;
  logic [SW-1:0]            stk_wd;
  logic                     live, can_push;

  assign idx        = SW'(cmd_q.item.slot);
  assign stk_ra     = SW'(depth_q - DW'(1));
  assign live       = (ph_rd_q == PH_RECORDED) || (ph_rd_q == PH_PUBLISHED);
  assign can_push   = (depth_q != SLOTS_D);
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    depth_d     = depth_q;
    wk_d        = wk_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    cnt_d       = cnt_q;
    rd_addr     = idx;
    pop_o       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    ph_we       = 1'b0;
    ph_wa       = idx;
    ph_wd       = PH_FREE;
    lr_we       = 1'b0;
    lr_wa       = idx;
    lr_wd       = '0;
    rm_we       = 1'b0;
    stk_we      = 1'b0;
    stk_wa      = SW'(depth_q);
    stk_wd      = idx;
    case (state_q)
      S_CLEAR: begin
        // Free every slot and stack them descending, slot 1 on top
        ph_we  = 1'b1;
        ph_wa  = clr_q;
        stk_we = 1'b1;
        stk_wa = clr_q;
        stk_wd = SLOTS_M1 - clr_q;
        clr_d  = clr_q + SW'(1);
        if (clr_q == SLOTS_M1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = SW'(work_i.item.slot);
        if (valid_i) begin
          pop_o   = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!cmd_q.badarg && cmd_q.item.command == CMD_COLLECT) begin
          state_d  = S_WALK;
          wk_d     = (SW + 1)'(1);
          ev_vld_d = 1'b0;
          cnt_d    = '0;
        end else if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          if (cmd_q.badarg) begin
            res_o.status = ST_BADARG;
          end else begin
            case (cmd_q.item.command)
              CMD_RESERVE: begin
                if (depth_q == '0) begin
                  res_o.status = ST_EXHAUSTED;
                end else begin
                  res_o.granted_slot = DRSP_SLOT_W'(stk_rd_q);
                  ph_we   = 1'b1;
                  ph_wa   = stk_rd_q;
                  ph_wd   = PH_RESERVED;
                  lr_we   = 1'b1;
                  lr_wa   = stk_rd_q;
                  depth_d = depth_q - DW'(1);
                end
              end
              CMD_MARK: begin
                if (ph_rd_q == PH_RESERVED) begin
                  ph_we = 1'b1;
                  ph_wd = PH_RECORDED;
                end else begin
                  res_o.status = ST_BADSTATE;
                end
              end
              CMD_ABANDON: begin
                if (ph_rd_q == PH_RESERVED || ph_rd_q == PH_RECORDED) begin
                  ph_we = 1'b1;
                  if (can_push) begin
                    stk_we  = 1'b1;
                    depth_d = depth_q + DW'(1);
                  end
                end else begin
                  res_o.status = ST_BADSTATE;
                end
              end
              CMD_PUBLISH: begin
                if (ph_rd_q == PH_RECORDED) begin
                  ph_we = 1'b1;
                  ph_wd = PH_PUBLISHED;
                end else begin
                  res_o.status = ST_BADSTATE;
                end
              end
              CMD_REFERENCE: begin
                if (live) begin
                  lr_we = (cmd_q.item.serial > lr_rd_q);
                  lr_wd = cmd_q.item.serial;
                end else begin
                  res_o.status = ST_BADSTATE;
                end
              end
              CMD_RETIRE: begin
                if (live) begin
                  ph_we = 1'b1;
                  ph_wd = PH_RETIRED;
                  rm_we = 1'b1;
                end else begin
                  res_o.status = ST_BADSTATE;
                end
              end
              default: begin
                res_o.status = ST_BADARG;
              end
            endcase
          end
        end
      end
      S_WALK: begin
        // Read slot wk while judging the slot read on the previous beat
        rd_addr = wk_q[SW-1:0];
        if (ev_vld_q && ph_rd_q == PH_RETIRED && rm_rd_q <= cmd_q.item.serial) begin
          ph_we  = 1'b1;
          ph_wa  = ev_idx_q;
          cnt_d  = cnt_q + DRSP_SLOT_W'(1);
          stk_wd = ev_idx_q;
          if (can_push) begin
            stk_we  = 1'b1;
            depth_d = depth_q + DW'(1);
          end
        end
        if (wk_q != SLOTS_WK) begin
          wk_d     = wk_q + (SW + 1)'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = wk_q[SW-1:0];
        end else begin
          ev_vld_d = 1'b0;
          if (!ev_vld_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          res_valid_o           = 1'b1;
          res_o.collected_count = cnt_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ph_rd_q  <= phase_mem[rd_addr];
    lr_rd_q  <= lr_mem[rd_addr];
    rm_rd_q  <= rm_mem[rd_addr];
    stk_rd_q <= stk_mem[stk_ra];
    if (ph_we) begin
      phase_mem[ph_wa] <= ph_wd;
    end
    if (lr_we) begin
      lr_mem[lr_wa] <= lr_wd;
    end
    if (rm_we) begin
      rm_mem[idx] <= lr_rd_q;
    end
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= work_i;
    end
    ev_idx_q <= ev_idx_d;
    wk_q     <= wk_d;
    cnt_q    <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      depth_q  <= DW'(SLOTS - 1);
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      depth_q  <= depth_d;
      ev_vld_q <= ev_vld_d;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= SLOTS_D)
    else $error("free stack depth beyond pool size");
  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK && cmd_q.item.command == CMD_RESERVE &&
     state_q == S_EXEC) |-> (stk_rd_q != '0))
    else $error("sentinel slot handed out");
  a_eval_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == S_WALK))
    else $error("walk stage live outside collect");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_EXEC))
    else $error("command taken without execution");
`endif

endmodule
`default_nettype wire

/* rtl/deferred_reclaim_slot_pool.sv */
// A per-slot command or reserve passes the front queue, the back end's idle and
// execute states and the output register. Collect sweeps slots 1..SLOTS-1 through
// the phase memory, one slot a beat, and then reports its count from the done state.
// Two commands may wait in the front queue while the back end works on a third.
// After reset a clearing pass over every slot initialises the phase memory and
// free stack; full stays high until it finishes.
`default_nettype none
module deferred_reclaim_slot_pool import drsp_pkg::*; #(
  parameter int SLOTS = DRSP_SLOTS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  input  wire logic     pop,
  output logic          empty,
  output out_item_t     out_item_o
);

  logic      clearing, q_valid, q_pop;
  work_t     q_work;
  logic      res_valid, res_ready;
  out_item_t res;
  logic      out_vld_q;
  out_item_t out_q;

  // Front end: range-check and classify, then hold up to two commands
  drsp_front #(.SLOTS(SLOTS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .hold_i  (clearing),
    .valid_o (q_valid),
    .work_o  (q_work),
    .pop_i   (q_pop)
  );

  // Back end: owns every per-slot store and the free stack
  drsp_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .work_i      (q_work),
    .pop_o       (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .clearing_o  (clearing)
  );

  // Output register: accept a new result beat whenever the slot is free or draining
  assign res_ready  = !out_vld_q || pop;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

endmodule
`default_nettype wire

/* sim/drsp_checker.sv */
// Checker for the slot pool: predicts each result beat and compares it.
`timescale 1ns / 1ps
module drsp_checker import drsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire logic      full_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      pop_i,
  input  wire logic      empty_i,
  input  wire out_item_t out_item_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             done_count_o
);
  logic [DRSP_PHASE_W-1:0]  phase_q [DRSP_SLOTS];
  logic [DRSP_SERIAL_W-1:0] reader_q [DRSP_SLOTS];
  logic [DRSP_SERIAL_W-1:0] mark_q [DRSP_SLOTS];
  logic [DRSP_SLOT_W-1:0]   stack_q [DRSP_SLOTS];
  int                       depth_q;
  out_item_t                expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic live(input logic [DRSP_PHASE_W-1:0] ph);
    return ph == PH_RECORDED || ph == PH_PUBLISHED;
  endfunction

  function automatic void free_slot(input int s);
    if (depth_q < DRSP_SLOTS) begin
      stack_q[depth_q] = s[DRSP_SLOT_W-1:0];
      depth_q++;
    end
  endfunction

  function automatic out_item_t predict_pool(input in_item_t it);
    out_item_t r;
    int s;
    int cnt;
    logic [DRSP_PHASE_W-1:0] ph;
    r = '0;
    s = it.slot;
    cnt = 0;
    if (it.command == CMD_RESERVE) begin
      if (depth_q == 0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        depth_q--;
        r.granted_slot = stack_q[depth_q];
        phase_q[r.granted_slot] = PH_RESERVED;
        reader_q[r.granted_slot] = '0;
        mark_q[r.granted_slot] = '0;
      end
    end else if (it.command == CMD_COLLECT) begin
      for (int i = 1; i < DRSP_SLOTS; i++) begin
        if (phase_q[i] == PH_RETIRED && mark_q[i] <= it.serial) begin
          phase_q[i] = PH_FREE;
          reader_q[i] = '0;
          mark_q[i] = '0;
          free_slot(i);
          cnt++;
        end
      end
      r.collected_count = cnt[DRSP_SLOT_W-1:0];
    end else if (it.command == CMD_UNUSED || s == 0 || s >= DRSP_SLOTS) begin
      r.status = ST_BADARG;
    end else begin
      ph = phase_q[s];
      r.status = ST_BADSTATE;
      case (it.command)
        CMD_MARK: if (ph == PH_RESERVED) begin
          phase_q[s] = PH_RECORDED;
          r.status = ST_OK;
        end
        CMD_ABANDON: if (ph == PH_RESERVED || ph == PH_RECORDED) begin
          phase_q[s] = PH_FREE;
          free_slot(s);
          r.status = ST_OK;
        end
        CMD_PUBLISH: if (ph == PH_RECORDED) begin
          phase_q[s] = PH_PUBLISHED;
          r.status = ST_OK;
        end
        CMD_REFERENCE: if (live(ph)) begin
          if (it.serial > reader_q[s]) reader_q[s] = it.serial;
          r.status = ST_OK;
        end
        default: if (live(ph)) begin
          phase_q[s] = PH_RETIRED;
          mark_q[s] = reader_q[s];
          r.status = ST_OK;
        end
      endcase
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DRSP_SLOTS; i++) begin
        phase_q[i] = PH_FREE;
        reader_q[i] = '0;
        mark_q[i] = '0;
        stack_q[i] = (i < DRSP_SLOTS - 1) ? DRSP_SLOT_W'(DRSP_SLOTS - 1 - i) : '0;
      end
      depth_q = DRSP_SLOTS - 1;
      expected_q.delete();
      fail_count_o <= 0;
      done_count_o <= 0;
    end else begin
      // check the result beat first so a same-edge prediction cannot be compared early
      if (pop_i && !empty_i) begin
        done_count_o <= done_count_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("mismatch: unexpected result %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          automatic out_item_t e = expected_q.pop_front();
          if (e.status !== out_item_i.status || e.granted_slot !== out_item_i.granted_slot ||
              e.collected_count !== out_item_i.collected_count) begin
            if (fail_count_o < 10)
              $display("mismatch: expected st=%0d slot=%0d cnt=%0d got st=%0d slot=%0d cnt=%0d",
                       e.status, e.granted_slot, e.collected_count, out_item_i.status,
                       out_item_i.granted_slot, out_item_i.collected_count);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push_i && !full_i) expected_q.push_back(predict_pool(in_item_i));
    end
  end
endmodule

/* sim/tb_deferred_reclaim_slot_pool.sv */
// Testbench top: stimulus, idling, pressure and verdict for the slot pool.
`timescale 1ns / 1ps
module tb_deferred_reclaim_slot_pool;
  import drsp_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push_q = 1'b0;
  logic      pop_q = 1'b0;
  logic      full_w;
  logic      empty_w;
  in_item_t  cmd_beat = '0;
  out_item_t res_beat;
  int        fails;
  int        pending;
  int        done;
  int        cycle_count = 0;
  int        sent = 0;
  bit        stim_done = 1'b0;
  bit        hold_off = 1'b0;
  bit        calm = 1'b0;
  int        pop_wait;
  int        live_slots [$];

  localparam int CYCLE_LIMIT = 400000;

  deferred_reclaim_slot_pool uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push_q), .full(full_w), .in_item_i(cmd_beat),
    .pop(pop_q), .empty(empty_w), .out_item_o(res_beat)
  );

  drsp_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push_q), .full_i(full_w), .in_item_i(cmd_beat),
    .pop_i(pop_q), .empty_i(empty_w), .out_item_i(res_beat), .fail_count_o(fails),
    .pending_o(pending), .done_count_o(done)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run if something hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Draw a random 64-bit serial, biased to the extremes and small values
  function automatic logic [63:0] rand_serial();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 40));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offer one beat and hold it until the pool accepts it; push stays high
  // into the next beat unless the sender idles
  task automatic send_beat(input logic [2:0] c, input logic [5:0] s, input logic [63:0] ser);
    while (!calm && $urandom_range(0, 99) < 19) begin
      push_q <= 1'b0;
      @(negedge clk_i);
    end
    cmd_beat <= '{command: c, slot: s, serial: ser};
    push_q <= 1'b1;
    @(posedge clk_i);
    while (full_w) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Pick a slot the sender believes is in use, or else any slot
  function automatic logic [5:0] pick_slot();
    if (live_slots.size() > 0 && $urandom_range(0, 9) < 8)
      return live_slots[$urandom_range(0, live_slots.size() - 1)];
    return 6'($urandom());
  endfunction

  // Receiver: random stalls, a calm stretch, and one long hold-off
  always @(negedge clk_i) begin
    if (hold_off) pop_q <= 1'b0;
    else pop_q <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
  end

  initial begin
    pop_wait = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first grants, every command, the sentinel slot and bad phases
    send_beat(CMD_RESERVE, 0, 0);
    send_beat(CMD_RESERVE, 0, 0);
    send_beat(CMD_MARK, 1, 0);
    send_beat(CMD_MARK, 1, 0);
    send_beat(CMD_PUBLISH, 1, 0);
    send_beat(CMD_REFERENCE, 1, '1);
    send_beat(CMD_REFERENCE, 1, 5);
    send_beat(CMD_RETIRE, 1, 0);
    send_beat(CMD_RETIRE, 1, 0);
    send_beat(CMD_COLLECT, 0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_beat(CMD_COLLECT, 0, '1);
    send_beat(CMD_ABANDON, 2, 0);
    send_beat(CMD_ABANDON, 2, 0);
    send_beat(CMD_MARK, 0, 0);
    send_beat(CMD_PUBLISH, 63, 0);
    send_beat(CMD_UNUSED, 5, '1);
    send_beat(CMD_REFERENCE, 3, 0);

    // Exhaust the stack, with the receiver held off so the pool fills and stalls
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 66; i++) send_beat(CMD_RESERVE, 0, 0);
        push_q <= 1'b0;
      end
      begin
        while (pop_wait < 300) begin
          @(posedge clk_i);
          pop_wait++;
        end
        hold_off = 1'b0;
      end
    join
    // Reserved slots 1..63 in some order: walk them to retired with serials
    for (int s = 1; s < 64; s++) begin
      send_beat(CMD_MARK, 6'(s), 0);
      send_beat(CMD_REFERENCE, 6'(s), 64'(s));
      send_beat(CMD_RETIRE, 6'(s), 0);
    end
    send_beat(CMD_COLLECT, 0, 30);
    send_beat(CMD_COLLECT, 0, 0);
    send_beat(CMD_COLLECT, 0, '1);

    // Random: mostly lifecycle-shaped traffic on slots in use, some noise
    while (sent < 900) begin
      calm = (sent > 500 && sent < 600);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          send_beat(CMD_RESERVE, 6'($urandom()), rand_serial());
          if (live_slots.size() < 20) live_slots.push_back(6'($urandom_range(1, 63)));
        end
        4, 5, 6: send_beat(CMD_MARK, pick_slot(), rand_serial());
        7, 8: send_beat(CMD_PUBLISH, pick_slot(), rand_serial());
        9, 10, 11: send_beat(CMD_REFERENCE, pick_slot(), rand_serial());
        12, 13: send_beat(CMD_RETIRE, pick_slot(), rand_serial());
        14: send_beat(CMD_ABANDON, pick_slot(), rand_serial());
        15, 16: send_beat(CMD_COLLECT, 6'($urandom()), rand_serial());
        17: send_beat(CMD_UNUSED, 6'($urandom()), rand_serial());
        default: send_beat(3'($urandom()), 6'($urandom()), rand_serial());
      endcase
      if ($urandom_range(0, 49) == 0) live_slots.delete();
    end
    push_q <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d commands covering reserve to exhaustion, full lifecycles and sweeps;",
             sent);
    $display("checked %0d results under random stalls and a long receiver hold-off.", done);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* deferred_reclaim_slot_pool.f */
rtl/drsp_pkg.sv
rtl/drsp_front.sv
rtl/drsp_back.sv
rtl/deferred_reclaim_slot_pool.sv
sim/drsp_checker.sv
sim/tb_deferred_reclaim_slot_pool.sv
